>>> hw/rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared constants and types for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'h55;
    localparam logic [7:0] SYNC_SECOND  = 8'hAA;
    localparam logic [15:0] HEADER_FLOOR = 16'd5;

    localparam logic [15:0] MIN_LEN_RESET = 16'd8;
    localparam logic [15:0] MAX_LEN_RESET = 16'd128;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = 2'd1;

    localparam logic [2:0] PH_SYNC0 = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_LENHI = 3'd2;
    localparam logic [2:0] PH_LENLO = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_CSUM  = 2'd1;
    localparam logic [1:0] ST_BADL  = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    typedef struct packed {
        logic [1:0] frame_status;
        logic       in_frame;
    } slcd_user_t;

endpackage

>>> hw/rtl/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Finds 0x55 0xAA framed messages with a big-endian total length and an
// additive checksum, and echoes every byte with frame marks and status.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock while the output side is not
// stalled, and returns exactly one word per byte. A byte is held in an
// input register, the frame state and the 8-bit running sum are updated
// from it combinationally, and the marked byte is placed in an output
// register; that per-byte update sets the rate of one word a cycle.
// The minimum and maximum frame lengths may be written only while no word is
// in flight.
module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] byte_in
    input  logic                   s_axis_tlast,   // end_of_burst
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] byte_out
    output logic                   m_axis_tlast,   // frame_last
    output logic [2:0]             m_axis_tuser,   // [0] in_frame, [2:1] frame_status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic        advance;

    logic [15:0] min_len_reg;
    logic [15:0] max_len_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] exp_len_reg, exp_len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  sum_reg, sum_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    slcd_user_t  out_user_reg;

    logic        inf;
    logic        last;
    logic [1:0]  status;
    logic [15:0] len_full;
    logic [15:0] seen_inc;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    assign len_full = {exp_len_reg[15:8], in_byte_reg};
    assign seen_inc = seen_reg + 16'd1;

    always_comb
    begin
        inf          = 1'b0;
        last         = 1'b0;
        status       = ST_GOOD;
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        case (phase_reg)
            PH_SYNC1:
            begin
                if (in_byte_reg == SYNC_SECOND)
                begin
                    inf        = 1'b1;
                    sum_next   = sum_reg + in_byte_reg;
                    seen_next  = 16'd2;
                    phase_next = PH_LENHI;
                end
                else if (in_byte_reg == SYNC_FIRST)
                begin
                    inf          = 1'b1;
                    phase_next   = PH_SYNC1;
                    sum_next     = in_byte_reg;
                    seen_next    = 16'd1;
                    exp_len_next = 16'd0;
                end
                else
                begin
                    phase_next   = PH_SYNC0;
                    sum_next     = 8'd0;
                    seen_next    = 16'd0;
                    exp_len_next = 16'd0;
                end
            end
            PH_LENHI:
            begin
                inf          = 1'b1;
                exp_len_next = {in_byte_reg, 8'd0};
                sum_next     = sum_reg + in_byte_reg;
                seen_next    = 16'd3;
                phase_next   = PH_LENLO;
            end
            PH_LENLO:
            begin
                inf          = 1'b1;
                exp_len_next = len_full;
                sum_next     = sum_reg + in_byte_reg;
                seen_next    = 16'd4;
                phase_next   = PH_BODY;
                if (len_full < HEADER_FLOOR || len_full < min_len_reg
                    || len_full > max_len_reg)
                begin
                    last   = 1'b1;
                    status = ST_BADL;
                end
            end
            PH_BODY:
            begin
                inf       = 1'b1;
                seen_next = seen_inc;
                if (seen_inc >= exp_len_reg)
                begin
                    last   = 1'b1;
                    status = (in_byte_reg == sum_reg) ? ST_GOOD : ST_CSUM;
                end
                else
                begin
                    sum_next = sum_reg + in_byte_reg;
                end
            end
            default:
            begin
                if (in_byte_reg == SYNC_FIRST)
                begin
                    inf          = 1'b1;
                    phase_next   = PH_SYNC1;
                    sum_next     = in_byte_reg;
                    seen_next    = 16'd1;
                    exp_len_next = 16'd0;
                end
                else
                begin
                    phase_next   = PH_SYNC0;
                    sum_next     = 8'd0;
                    seen_next    = 16'd0;
                    exp_len_next = 16'd0;
                end
            end
        endcase
        if (inf && !last && in_eob_reg)
        begin
            last   = 1'b1;
            status = ST_TRUNC;
        end
        if (last)
        begin
            phase_next   = PH_SYNC0;
            sum_next     = 8'd0;
            seen_next    = 16'd0;
            exp_len_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MIN_LEN)
            begin
                min_len_reg <= cfg_data;
            end
            else if (cfg_index == REG_MAX_LEN)
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SYNC0;
            exp_len_reg   <= 16'd0;
            seen_reg      <= 16'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                exp_len_reg   <= exp_len_next;
                seen_reg      <= seen_next;
                sum_reg       <= sum_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eob_reg  <= s_axis_tlast;
        end
        if (advance)
        begin
            out_byte_reg              <= in_byte_reg;
            out_last_reg              <= last;
            out_user_reg.in_frame     <= inf;
            out_user_reg.frame_status <= status;
        end
    end

endmodule

>>> hw/rtl/slcd_checker.sv
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module slcd_checker
    import slcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic                   m_axis_tlast,
    input logic [2:0]             m_axis_tuser
);

    // A waiting output word must not be withdrawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    // The input side only stalls when a finished word is waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // A frame end is always a byte inside a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("frame end outside a frame");

    // A nonzero status appears only on a frame end.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_GOOD |-> m_axis_tlast)
        else $error("status reported on a byte that does not end a frame");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Drives byte words into the sync/length/checksum deframer and checks every
// echoed word, with its frame marks and end status, against a cycle-free
// prediction of the frame hunt. The run covers directed corner cases and
// random well-formed, corrupted, cut and rejected frames mixed with noise,
// under several length limits and with random stalls on both sides.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] data;
    logic       in_frame;
    logic       last;
    logic [1:0] status;
} word_mark_t;

class frame_marks;
    logic [2:0]  phase;
    logic [15:0] want_len;
    logic [15:0] count;
    logic [7:0]  sum;
    logic [15:0] min_len;
    logic [15:0] max_len;
    word_mark_t  pending_marks[$];
    int          errors;
    int          words_checked;
    int          ends_by_status[4];

    function new();
        min_len = slcd_pkg::MIN_LEN_RESET;
        max_len = slcd_pkg::MAX_LEN_RESET;
        errors = 0;
        words_checked = 0;
        ends_by_status = '{0, 0, 0, 0};
        hunt();
    endfunction

    function void hunt();
        phase = slcd_pkg::PH_SYNC0;
        want_len = '0;
        count = '0;
        sum = '0;
    endfunction

    function void open_candidate(logic [7:0] v);
        phase = slcd_pkg::PH_SYNC1;
        sum = v;
        count = 16'd1;
        want_len = '0;
    endfunction

    function void set_reg(logic [slcd_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] value);
        if (idx == slcd_pkg::REG_MIN_LEN)
            min_len = value;
        else if (idx == slcd_pkg::REG_MAX_LEN)
            max_len = value;
    endfunction

    function void note_byte(logic [7:0] v, logic eob);
        word_mark_t m;
        m.data = v;
        m.in_frame = 1'b0;
        m.last = 1'b0;
        m.status = slcd_pkg::ST_GOOD;
        case (phase)
            slcd_pkg::PH_SYNC1:
            begin
                if (v == slcd_pkg::SYNC_SECOND)
                begin
                    m.in_frame = 1'b1;
                    sum = sum + v;
                    count = 16'd2;
                    phase = slcd_pkg::PH_LENHI;
                end
                else if (v == slcd_pkg::SYNC_FIRST)
                begin
                    m.in_frame = 1'b1;
                    open_candidate(v);
                end
                else
                begin
                    hunt();
                end
            end
            slcd_pkg::PH_LENHI:
            begin
                m.in_frame = 1'b1;
                want_len = {v, 8'h00};
                sum = sum + v;
                count = 16'd3;
                phase = slcd_pkg::PH_LENLO;
            end
            slcd_pkg::PH_LENLO:
            begin
                m.in_frame = 1'b1;
                want_len[7:0] = v;
                sum = sum + v;
                count = 16'd4;
                phase = slcd_pkg::PH_BODY;
                if (want_len < slcd_pkg::HEADER_FLOOR || want_len < min_len ||
                    want_len > max_len)
                begin
                    m.last = 1'b1;
                    m.status = slcd_pkg::ST_BADL;
                end
            end
            slcd_pkg::PH_BODY:
            begin
                m.in_frame = 1'b1;
                count = count + 16'd1;
                if (count >= want_len)
                begin
                    m.last = 1'b1;
                    m.status = (v == sum) ? slcd_pkg::ST_GOOD : slcd_pkg::ST_CSUM;
                end
                else
                begin
                    sum = sum + v;
                end
            end
            default:
            begin
                if (v == slcd_pkg::SYNC_FIRST)
                begin
                    m.in_frame = 1'b1;
                    open_candidate(v);
                end
                else
                begin
                    hunt();
                end
            end
        endcase
        if (m.in_frame && !m.last && eob)
        begin
            m.last = 1'b1;
            m.status = slcd_pkg::ST_TRUNC;
        end
        if (m.last)
            hunt();
        pending_marks.push_back(m);
    endfunction

    function void compare(string what, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function void check_word(logic [7:0] data, logic last, logic [2:0] user);
        slcd_pkg::slcd_user_t u;
        word_mark_t m;
        u = slcd_pkg::slcd_user_t'(user);
        if (pending_marks.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word, expected none, actual data %0h last %0b user %0h",
                     $time, data, last, user);
            return;
        end
        m = pending_marks.pop_front();
        words_checked++;
        compare("byte_out", m.data, data);
        compare("in_frame", m.in_frame, u.in_frame);
        compare("frame_last", m.last, last);
        compare("frame_status", m.status, u.frame_status);
        if (m.last)
            ends_by_status[m.status]++;
    endfunction

    function void close();
        if (pending_marks.size() != 0)
        begin
            errors++;
            $display("%0t: %0d words expected, actual none arrived", $time,
                     pending_marks.size());
        end
    endfunction
endclass

module tb;
    import slcd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tlast;
    logic [2:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data = '0;

    frame_marks tracker = new();
    int send_idle_pct = 18;
    int recv_idle_pct = 45;
    int bytes_sent = 0;

    sync_length_checksum_deframer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.note_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Run did not complete within the time limit.");
        $display("FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] v, input logic eob);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tlast <= eob;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stop_stream();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending_marks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic apply_limits(input logic [15:0] min_len, input logic [15:0] max_len);
        stop_stream();
        wait_drained();
        write_reg(REG_MIN_LEN, min_len);
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_MAX_LEN, max_len);
        write_reg(REG_SPARE_B, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // A frame of total length len, of which the first nbytes are sent; a cut
    // position puts end of burst on that byte and drops the rest.
    task automatic send_frame(input logic [15:0] len, input int nbytes, input bit bad_sum,
                              input int cut_at, input bit eob_end);
        logic [7:0] s;
        logic [7:0] v;
        s = 8'h00;
        for (int i = 0; i < nbytes; i++)
        begin
            if (i == 0)
                v = SYNC_FIRST;
            else if (i == 1)
                v = SYNC_SECOND;
            else if (i == 2)
                v = len[15:8];
            else if (i == 3)
                v = len[7:0];
            else if (i == nbytes - 1)
                v = bad_sum ? s + 8'($urandom_range(1, 255)) : s;
            else
                v = 8'($urandom);
            if (i == cut_at)
            begin
                send_byte(v, 1'b1);
                return;
            end
            send_byte(v, eob_end && i == nbytes - 1);
            s = s + v;
        end
    endtask

    function automatic bit length_rejected(logic [15:0] len);
        return len < HEADER_FLOOR || len < tracker.min_len || len > tracker.max_len;
    endfunction

    function automatic logic [15:0] pick_bad_len();
        logic [15:0] cand;
        do
        begin
            case ($urandom_range(0, 3))
                0: cand = 16'($urandom_range(0, 7));
                1: cand = tracker.min_len - 16'd1;
                2: cand = tracker.max_len + 16'd1;
                default: cand = 16'($urandom);
            endcase
        end
        while (!length_rejected(cand));
        return cand;
    endfunction

    task automatic pick_good_len(output logic [15:0] len, output bit ok);
        int lo;
        int hi;
        lo = (tracker.min_len > HEADER_FLOOR) ? tracker.min_len : HEADER_FLOOR;
        hi = (tracker.max_len < 48) ? tracker.max_len : 48;
        ok = lo <= hi;
        len = '0;
        if (ok)
        begin
            case ($urandom_range(0, 5))
                0: len = 16'(lo);
                1: len = 16'(hi);
                default: len = 16'($urandom_range(lo, hi));
            endcase
        end
    endtask

    task automatic random_chunk();
        logic [15:0] len;
        logic [7:0]  v;
        bit          ok;
        int          r;
        r = $urandom_range(0, 99);
        pick_good_len(len, ok);
        if (r < 75 && !ok)
            r = 75;
        if (r < 55)
        begin
            send_frame(len, len, 1'b0, -1, $urandom_range(0, 7) == 0);
        end
        else if (r < 65)
        begin
            send_frame(len, len, 1'b1, -1, $urandom_range(0, 7) == 0);
        end
        else if (r < 75)
        begin
            send_frame(len, len, 1'($urandom_range(0, 1)), $urandom_range(0, len - 2), 1'b0);
        end
        else if (r < 83)
        begin
            len = pick_bad_len();
            send_frame(len, 4, 1'b0, ($urandom_range(0, 3) == 0) ? 3 : -1, 1'b0);
        end
        else if (r < 90)
        begin
            send_byte(SYNC_FIRST, 1'b0);
            v = 8'($urandom);
            if (v == SYNC_SECOND)
                v = 8'h00;
            send_byte(v, $urandom_range(0, 5) == 0);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                v = 8'($urandom);
                if (v == SYNC_FIRST && $urandom_range(0, 3) != 0)
                    v = 8'h54;
                send_byte(v, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    task automatic random_phase(input int budget);
        int  start;
        bit  paused;
        start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < budget)
        begin
            random_chunk();
            if (!paused && bytes_sent - start >= budget / 2)
            begin
                stop_stream();
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 45;
        send_frame(16'd8, 8, 1'b0, -1, 1'b0);
        send_frame(16'd8, 8, 1'b1, -1, 1'b1);
        send_frame(16'd4, 4, 1'b0, 3, 1'b0);
        send_byte(SYNC_FIRST, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(SYNC_FIRST, 1'b0);
        send_frame(16'h00FF, 4, 1'b0, -1, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(SYNC_FIRST, 1'b1);

        apply_limits(16'd5, 16'hFFFF);
        send_frame(16'd700, 700, 1'b0, -1, 1'b0);
        random_phase(300);
        apply_limits(16'd0, 16'd20);
        random_phase(300);

        send_idle_pct = 45;
        recv_idle_pct = 18;
        apply_limits(16'hFFFF, 16'hFFFF);
        random_phase(150);
        apply_limits(16'd100, 16'd50);
        random_phase(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_limits(16'd5, 16'd5);
        random_phase(150);
        apply_limits(MIN_LEN_RESET, MAX_LEN_RESET);
        random_phase(250);

        stop_stream();
        wait_drained();
        tracker.close();
        $display("Sent %0d bytes under six length settings, %0d words checked.",
                 bytes_sent, tracker.words_checked);
        $display("Frame ends seen: good %0d, checksum error %0d, bad length %0d, truncated %0d.",
                 tracker.ends_by_status[ST_GOOD], tracker.ends_by_status[ST_CSUM],
                 tracker.ends_by_status[ST_BADL], tracker.ends_by_status[ST_TRUNC]);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
